/* src/vsbc_pkg.sv */
// Shared types, constants and command codes for the viewport stack blit clipper.
package vsbc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int COORD_BITS  = 16;

  localparam int POS_W     = 16;
  localparam int SIZE_W    = 15;
  localparam int CNT_W     = 8;
  localparam int COLOR_W   = 32;
  localparam int CFG_W     = 32;
  localparam int PADDR_W   = 3;
  localparam int IN_DATA_W = 168;

  localparam logic [SIZE_W-1:0] CANVAS_W_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] CANVAS_H_RESET = SIZE_W'(768);

  // register index, taken from paddr[2]
  localparam logic REG_CANVAS_W = 1'b0;
  localparam logic REG_CANVAS_H = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_BLIT = 2'd2,
    FUNC_FILL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BLIT = 2'd1,
    ACT_FILL = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_BLIT1,
    CMD_BLIT2,
    CMD_BLIT3,
    CMD_BLIT4,
    CMD_ISECT_A,
    CMD_ISECT_B,
    CMD_PUSH,
    CMD_POP_RD,
    CMD_POP_LD,
    CMD_RESULT
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  ovf;
    logic  pop_move;
  } status_t;

  typedef struct packed {
    logic [SIZE_W-1:0] canvas_width;
    logic [SIZE_W-1:0] canvas_height;
  } cfg_t;

  typedef struct packed {
    func_t                    func;
    logic                     has_rect;
    logic signed [POS_W-1:0]  rect_x;
    logic signed [POS_W-1:0]  rect_y;
    logic [SIZE_W-1:0]        rect_w;
    logic [SIZE_W-1:0]        rect_h;
    logic signed [POS_W-1:0]  src_x;
    logic signed [POS_W-1:0]  src_y;
    logic [SIZE_W-1:0]        img_w;
    logic [SIZE_W-1:0]        img_h;
    logic [CNT_W-1:0]         unwind_count;
    logic [COLOR_W-1:0]       fill_color;
  } item_t;

  typedef struct packed {
    action_t                  action;
    logic signed [POS_W-1:0]  dst_out_x;
    logic signed [POS_W-1:0]  dst_out_y;
    logic signed [POS_W-1:0]  src_out_x;
    logic signed [POS_W-1:0]  src_out_y;
    logic [SIZE_W-1:0]        out_w;
    logic [SIZE_W-1:0]        out_h;
    logic [COLOR_W-1:0]       color_out;
    logic                     overflow;
  } result_t;

endpackage

/* src/vsbc_regs.sv */
// Configuration register file on the APB-style port: canvas width and height.
module vsbc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsbc_pkg::PADDR_W-1:0]  paddr,
  input  logic [vsbc_pkg::CFG_W-1:0]    pwdata,
  output logic [vsbc_pkg::CFG_W-1:0]    prdata,
  output logic                          pready,
  output vsbc_pkg::cfg_t                cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width  <= vsbc_pkg::CANVAS_W_RESET;
      cfg.canvas_height <= vsbc_pkg::CANVAS_H_RESET;
    end else if (wr_en) begin
      if (paddr[2] == vsbc_pkg::REG_CANVAS_W) begin
        cfg.canvas_width <= pwdata[vsbc_pkg::SIZE_W-1:0];
      end else begin
        cfg.canvas_height <= pwdata[vsbc_pkg::SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == vsbc_pkg::REG_CANVAS_W) begin
      prdata = vsbc_pkg::CFG_W'(cfg.canvas_width);
    end else begin
      prdata = vsbc_pkg::CFG_W'(cfg.canvas_height);
    end
  end

endmodule

/* src/vsbc_ctrl.sv */
// Sequencer: steps one request through the clip datapath and owns the handshakes.
module vsbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  vsbc_pkg::status_t status,
  output vsbc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_BLIT1,
    S_BLIT2,
    S_BLIT3,
    S_BLIT4,
    S_ISECT_A,
    S_ISECT_B,
    S_PUSH,
    S_POP_RD,
    S_POP_LD,
    S_RESULT
  } state_t;

  state_t state;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      S_IDLE:     cmd = (s_tready && s_tvalid) ? vsbc_pkg::CMD_LOAD : vsbc_pkg::CMD_NONE;
      S_BLIT1:    cmd = vsbc_pkg::CMD_BLIT1;
      S_BLIT2:    cmd = vsbc_pkg::CMD_BLIT2;
      S_BLIT3:    cmd = vsbc_pkg::CMD_BLIT3;
      S_BLIT4:    cmd = vsbc_pkg::CMD_BLIT4;
      S_ISECT_A:  cmd = vsbc_pkg::CMD_ISECT_A;
      S_ISECT_B:  cmd = vsbc_pkg::CMD_ISECT_B;
      S_PUSH:     cmd = vsbc_pkg::CMD_PUSH;
      S_POP_RD:   cmd = vsbc_pkg::CMD_POP_RD;
      S_POP_LD:   cmd = vsbc_pkg::CMD_POP_LD;
      S_RESULT:   cmd = out_free ? vsbc_pkg::CMD_RESULT : vsbc_pkg::CMD_NONE;
      default:    cmd = vsbc_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result may load at the edge the previous one is taken
      if (state == S_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!s_tready) begin
            s_tready <= 1'b1;
          end else if (s_tvalid) begin
            s_tready <= 1'b0;
            state    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (status.func)
            vsbc_pkg::FUNC_PUSH: state <= status.ovf ? S_RESULT : S_ISECT_A;
            vsbc_pkg::FUNC_POP:  state <= status.pop_move ? S_POP_RD : S_RESULT;
            vsbc_pkg::FUNC_BLIT: state <= S_BLIT1;
            default:             state <= S_ISECT_A;
          endcase
        end
        S_BLIT1:   state <= S_BLIT2;
        S_BLIT2:   state <= S_BLIT3;
        S_BLIT3:   state <= S_BLIT4;
        S_BLIT4:   state <= S_RESULT;
        S_ISECT_A: state <= S_ISECT_B;
        S_ISECT_B: state <= (status.func == vsbc_pkg::FUNC_PUSH) ? S_PUSH : S_RESULT;
        S_PUSH:    state <= S_RESULT;
        S_POP_RD:  state <= S_POP_LD;
        S_POP_LD:  state <= S_RESULT;
        S_RESULT: begin
          if (out_free) begin
            s_tready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/vsbc_dp.sv */
// Datapath: viewport stack, top-entry cache, per-axis clip unit and result register.
module vsbc_dp #(
  parameter int  STACK_DEPTH = vsbc_pkg::STACK_DEPTH,
  parameter int  COORD_BITS  = vsbc_pkg::COORD_BITS,
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vsbc_pkg::cmd_t       cmd,
  input  vsbc_pkg::item_t      item,
  input  vsbc_pkg::cfg_t       cfg,
  output vsbc_pkg::status_t    status,
  output vsbc_pkg::result_t    res,
  output logic [LEVEL_W-1:0]   stack_level
);

  localparam int TW    = $clog2(STACK_DEPTH);
  localparam int SW    = vsbc_pkg::SIZE_W;
  localparam int PW    = vsbc_pkg::POS_W;
  localparam int WW    = ((COORD_BITS > PW) ? COORD_BITS : PW) + 4;
  localparam int ENT_W = 4 * COORD_BITS + 2 * SW;
  localparam int UW    = ((TW > vsbc_pkg::CNT_W) ? TW : vsbc_pkg::CNT_W) + 1;
  localparam logic [TW-1:0] TOP_MAX = TW'(STACK_DEPTH - 1);

  // top-of-stack cache
  logic [TW-1:0]                 top;
  logic signed [COORD_BITS-1:0]  org [2];
  logic signed [COORD_BITS-1:0]  cxy [2];
  logic [SW-1:0]                 cwh [2];

  // entries below the top
  logic [ENT_W-1:0]              mem [STACK_DEPTH];
  logic [ENT_W-1:0]              rd_data;
  logic [ENT_W-1:0]              cur_ent;

  // request held for the duration of its work
  vsbc_pkg::func_t               func;
  logic                          ovf;
  logic [vsbc_pkg::CNT_W-1:0]    unwind;
  logic [vsbc_pkg::COLOR_W-1:0]  color;
  logic [SW-1:0]                 img [2];
  logic signed [COORD_BITS-1:0]  new_org [2];

  // per-axis working registers: position, source / right edge, size
  logic signed [WW-1:0]          d [2];
  logic signed [WW-1:0]          s [2];
  logic [SW-1:0]                 n [2];
  logic signed [WW-1:0]          d_next [2];
  logic signed [WW-1:0]          s_next [2];
  logic [SW-1:0]                 n_next [2];

  // per-axis combinational terms
  logic signed [PW-1:0]          pos_in [2];
  logic signed [PW-1:0]          src_in [2];
  logic [SW-1:0]                 size_in [2];
  logic [SW-1:0]                 img_in [2];
  logic [SW-1:0]                 canvas [2];
  logic [SW-1:0]                 cw_eff [2];
  logic signed [WW-1:0]          cx_w [2];
  logic signed [WW-1:0]          cr_w [2];
  logic signed [WW-1:0]          d_sum [2];
  logic signed [WW-1:0]          wrap_w [2];
  logic signed [WW-1:0]          n_w [2];
  logic signed [WW-1:0]          iw_w [2];
  logic signed [WW-1:0]          e_w [2];
  logic signed [WW-1:0]          sn_w [2];
  logic signed [WW-1:0]          dn_w [2];

  logic [UW-1:0]                 pop_cnt;
  logic [UW-1:0]                 top_u;
  logic [UW-1:0]                 unw_u;
  logic [UW-1:0]                 newt_u;
  logic [TW-1:0]                 pop_top;
  logic                          blit_hit;
  logic                          fill_hit;

  function automatic logic [SW-1:0] sat0(input logic signed [WW-1:0] v);
    sat0 = v[WW-1] ? '0 : v[SW-1:0];
  endfunction

  assign pos_in[0]  = item.rect_x;
  assign pos_in[1]  = item.rect_y;
  assign src_in[0]  = item.src_x;
  assign src_in[1]  = item.src_y;
  assign size_in[0] = item.rect_w;
  assign size_in[1] = item.rect_h;
  assign img_in[0]  = item.img_w;
  assign img_in[1]  = item.img_h;
  assign canvas[0]  = cfg.canvas_width;
  assign canvas[1]  = cfg.canvas_height;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // base entry takes its size from the canvas registers
      cw_eff[a] = (top == '0) ? canvas[a] : cwh[a];
      cx_w[a]   = WW'(cxy[a]);
      cr_w[a]   = cx_w[a] + $signed(WW'(cw_eff[a]));
      d_sum[a]  = WW'(org[a]) + WW'(pos_in[a]);
      wrap_w[a] = WW'($signed(d_sum[a][COORD_BITS-1:0]));
      n_w[a]    = $signed(WW'(n[a]));
      iw_w[a]   = $signed(WW'(img[a]));
      e_w[a]    = cx_w[a] - d[a];
      sn_w[a]   = s[a] + n_w[a];
      dn_w[a]   = d[a] + n_w[a];
    end
  end

  // working registers: one clip step per command
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      d_next[a] = d[a];
      s_next[a] = s[a];
      n_next[a] = n[a];
      case (cmd)
        vsbc_pkg::CMD_LOAD: begin
          if (item.func == vsbc_pkg::FUNC_BLIT) begin
            d_next[a] = d_sum[a];
            n_next[a] = item.has_rect ? size_in[a] : img_in[a];
          end else if (item.has_rect) begin
            d_next[a] = (item.func == vsbc_pkg::FUNC_PUSH) ? wrap_w[a] : d_sum[a];
            n_next[a] = size_in[a];
          end else begin
            // no rectangle: intersecting the clip with itself keeps it
            d_next[a] = cx_w[a];
            n_next[a] = cw_eff[a];
          end
          s_next[a] = WW'(src_in[a]);
        end
        vsbc_pkg::CMD_BLIT1: begin
          if (s[a][WW-1]) begin
            n_next[a] = sat0(n_w[a] + s[a]);
            d_next[a] = d[a] - s[a];
            s_next[a] = '0;
          end
        end
        vsbc_pkg::CMD_BLIT2: begin
          if (d[a] < cx_w[a]) begin
            n_next[a] = sat0(n_w[a] - e_w[a]);
            s_next[a] = s[a] + e_w[a];
            d_next[a] = cx_w[a];
          end
        end
        vsbc_pkg::CMD_BLIT3: begin
          if (sn_w[a] > iw_w[a]) begin
            n_next[a] = sat0(iw_w[a] - s[a]);
          end
        end
        vsbc_pkg::CMD_BLIT4: begin
          if (dn_w[a] > cr_w[a]) begin
            n_next[a] = sat0(cr_w[a] - d[a]);
          end
        end
        vsbc_pkg::CMD_ISECT_A: begin
          d_next[a] = (d[a] > cx_w[a]) ? d[a] : cx_w[a];
          s_next[a] = (dn_w[a] < cr_w[a]) ? dn_w[a] : cr_w[a];
        end
        vsbc_pkg::CMD_ISECT_B: begin
          n_next[a] = sat0(s[a] - d[a]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      d[a] <= d_next[a];
      s[a] <= s_next[a];
      n[a] <= n_next[a];
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd == vsbc_pkg::CMD_LOAD) begin
      func   <= item.func;
      ovf    <= (item.func == vsbc_pkg::FUNC_PUSH) && (top == TOP_MAX);
      unwind <= item.unwind_count;
      color  <= item.fill_color;
      for (int a = 0; a < 2; a++) begin
        img[a]     <= img_in[a];
        new_org[a] <= item.has_rect ? $signed(d_sum[a][COORD_BITS-1:0]) : org[a];
      end
    end
  end

  // pop stops at the base entry
  assign top_u   = UW'(top);
  assign unw_u   = UW'(unwind);
  assign pop_cnt = (unw_u < top_u) ? unw_u : top_u;
  assign newt_u  = top_u - pop_cnt;
  assign pop_top = newt_u[TW-1:0];

  assign status.func     = func;
  assign status.ovf      = ovf;
  assign status.pop_move = (func == vsbc_pkg::FUNC_POP) && (unwind != '0) && (top != '0);

  assign cur_ent = {org[1], org[0], cxy[1], cxy[0], cwh[1], cwh[0]};

  always_ff @(posedge clk) begin
    if (cmd == vsbc_pkg::CMD_PUSH) begin
      mem[top] <= cur_ent;
    end
    if (cmd == vsbc_pkg::CMD_POP_RD) begin
      rd_data <= mem[pop_top];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      for (int a = 0; a < 2; a++) begin
        org[a] <= '0;
        cxy[a] <= '0;
        cwh[a] <= '0;
      end
    end else begin
      case (cmd)
        vsbc_pkg::CMD_PUSH: begin
          top <= top + 1'b1;
          for (int a = 0; a < 2; a++) begin
            org[a] <= new_org[a];
            cxy[a] <= $signed(d[a][COORD_BITS-1:0]);
            cwh[a] <= n[a];
          end
        end
        vsbc_pkg::CMD_POP_RD: begin
          top <= pop_top;
        end
        vsbc_pkg::CMD_POP_LD: begin
          cwh[0] <= rd_data[SW-1:0];
          cwh[1] <= rd_data[2*SW-1:SW];
          cxy[0] <= $signed(rd_data[2*SW +: COORD_BITS]);
          cxy[1] <= $signed(rd_data[2*SW+COORD_BITS +: COORD_BITS]);
          org[0] <= $signed(rd_data[2*SW+2*COORD_BITS +: COORD_BITS]);
          org[1] <= $signed(rd_data[2*SW+3*COORD_BITS +: COORD_BITS]);
        end
        default: begin
        end
      endcase
    end
  end

  assign blit_hit = (func == vsbc_pkg::FUNC_BLIT) && (n[0] != '0) && (n[1] != '0);
  assign fill_hit = (func == vsbc_pkg::FUNC_FILL) && (n[0] != '0) && (n[1] != '0);

  // result register; unused fields drop to zero
  always_ff @(posedge clk) begin
    if (cmd == vsbc_pkg::CMD_RESULT) begin
      res.action    <= blit_hit ? vsbc_pkg::ACT_BLIT :
                       (fill_hit ? vsbc_pkg::ACT_FILL : vsbc_pkg::ACT_NONE);
      res.dst_out_x <= (blit_hit || fill_hit) ? d[0][PW-1:0] : '0;
      res.dst_out_y <= (blit_hit || fill_hit) ? d[1][PW-1:0] : '0;
      res.src_out_x <= blit_hit ? s[0][PW-1:0] : '0;
      res.src_out_y <= blit_hit ? s[1][PW-1:0] : '0;
      res.out_w     <= (blit_hit || fill_hit) ? n[0] : '0;
      res.out_h     <= (blit_hit || fill_hit) ? n[1] : '0;
      res.color_out <= fill_hit ? color : '0;
      res.overflow  <= ovf;
      stack_level   <= LEVEL_W'(top) + LEVEL_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (rst) top <= TOP_MAX)
    else $error("stack top beyond last entry");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd == vsbc_pkg::CMD_PUSH |=> top == TW'($past(top) + 1'b1))
    else $error("push did not advance the stack top");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd == vsbc_pkg::CMD_PUSH |-> !ovf)
    else $error("push executed on a full stack");

  a_empty_action: assert property (@(posedge clk) disable iff (rst)
    cmd == vsbc_pkg::CMD_RESULT |=>
      ((res.action == vsbc_pkg::ACT_NONE) == (res.out_w == '0 || res.out_h == '0)))
    else $error("action disagrees with clipped size");
`endif

endmodule

/* src/viewport_stack_blit_clipper_top.sv */
// Top level of the viewport stack blit clipper: stream ports, register port, controller, datapath.
// Next request can be taken in the cycle after the result loads. Throughput is set by the sequencer,
// which steps the per-axis clip unit one rule per cycle. Synchronous reset leaves only the base
// viewport (origin 0,0, clip 0,0,1024x768) on the stack; the stack memory is not cleared and
// s_tready rises in the cycle after reset.
module viewport_stack_blit_clipper_top #(
  parameter int  STACK_DEPTH = vsbc_pkg::STACK_DEPTH,
  parameter int  COORD_BITS  = vsbc_pkg::COORD_BITS,
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1),
  localparam int M_DATA_W    = ((127 + LEVEL_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vsbc_pkg::PADDR_W-1:0]      paddr,
  input  logic [vsbc_pkg::CFG_W-1:0]        pwdata,
  output logic [vsbc_pkg::CFG_W-1:0]        prdata,
  output logic                              pready,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // rect_x, rect_y, rect_w, rect_h, src_x, src_y, img_w, img_h, unwind_count, fill_color
  input  logic [vsbc_pkg::IN_DATA_W-1:0]    s_tdata,
  // func, has_rect
  input  logic [2:0]                        s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // dst_out_x, dst_out_y, src_out_x, src_out_y, out_w, out_h, color_out, stack_level, overflow
  output logic [M_DATA_W-1:0]               m_tdata,
  // action
  output logic [1:0]                        m_tuser
);

  vsbc_pkg::cfg_t            cfg;
  vsbc_pkg::item_t           item;
  vsbc_pkg::status_t         status;
  vsbc_pkg::cmd_t            cmd;
  vsbc_pkg::result_t         res;
  logic [LEVEL_W-1:0]        stack_level;

  // unpack the request, lowest field first
  assign item.func         = vsbc_pkg::func_t'(s_tuser[1:0]);
  assign item.has_rect     = s_tuser[2];
  assign item.rect_x       = s_tdata[15:0];
  assign item.rect_y       = s_tdata[31:16];
  assign item.rect_w       = s_tdata[46:32];
  assign item.rect_h       = s_tdata[61:47];
  assign item.src_x        = s_tdata[77:62];
  assign item.src_y        = s_tdata[93:78];
  assign item.img_w        = s_tdata[108:94];
  assign item.img_h        = s_tdata[123:109];
  assign item.unwind_count = s_tdata[131:124];
  assign item.fill_color   = s_tdata[163:132];

  vsbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: holds s_tready low while a request is in flight
  vsbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // stack, clip unit and output register
  vsbc_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item        (item),
    .cfg         (cfg),
    .status      (status),
    .res         (res),
    .stack_level (stack_level)
  );

  // pack the result, lowest field first, zero padded to whole bytes
  assign m_tdata = M_DATA_W'({res.overflow, stack_level, res.color_out, res.out_h, res.out_w,
                              res.src_out_y, res.src_out_x, res.dst_out_y, res.dst_out_x});
  assign m_tuser = res.action;

endmodule

/* verif/vsbc_clip_checker.sv */
// Checker for the viewport stack blit clipper: tracks the stack, predicts each command, compares.
`timescale 1ns / 100ps

module vsbc_clip_checker
  import vsbc_pkg::*;
#(
  parameter int  LEVEL_W  = $clog2(STACK_DEPTH + 1),
  parameter int  M_DATA_W = ((127 + LEVEL_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [CFG_W-1:0]     pwdata,
  input  logic [CFG_W-1:0]     prdata,
  input  logic                 pready,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [2:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_DATA_W-1:0]  m_tdata,
  input  logic [1:0]           m_tuser,
  output int                   errors,
  output int                   outstanding
);

  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
  } box_t;

  typedef struct packed {
    action_t             action;
    logic [POS_W-1:0]    dst_x;
    logic [POS_W-1:0]    dst_y;
    logic [POS_W-1:0]    src_x;
    logic [POS_W-1:0]    src_y;
    logic [SIZE_W-1:0]   w;
    logic [SIZE_W-1:0]   h;
    logic [COLOR_W-1:0]  color;
    logic [LEVEL_W-1:0]  level;
    logic                ovf;
  } clip_cmd_t;

  logic [SIZE_W-1:0] canvas_w;
  logic [SIZE_W-1:0] canvas_h;
  longint            org_x [STACK_DEPTH];
  longint            org_y [STACK_DEPTH];
  box_t              clip_tbl [STACK_DEPTH];
  int unsigned       top_idx;
  clip_cmd_t         expected_cmds [$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic longint floor0(longint v);
    return (v < 0) ? 0 : v;
  endfunction

  function automatic longint wrap_coord(longint v);
    logic signed [COORD_BITS-1:0] t;
    t = v[COORD_BITS-1:0];
    return t;
  endfunction

  function automatic box_t overlap(box_t a, box_t b);
    box_t   r;
    longint x2;
    longint y2;
    x2  = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
    y2  = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
    r.x = (a.x > b.x) ? a.x : b.x;
    r.y = (a.y > b.y) ? a.y : b.y;
    r.w = floor0(x2 - r.x);
    r.h = floor0(y2 - r.y);
    return r;
  endfunction

  // Advance the stack model by one request and return the command it should produce.
  function automatic clip_cmd_t clip_request(logic [2:0] user, logic [IN_DATA_W-1:0] data);
    func_t       fn;
    logic        has_rect;
    longint      rx, ry, rw, rh, sx, sy, iw, ih;
    longint      ox, oy, dx, dy, psx, psy, w, h, d;
    int unsigned unwind, t, n;
    logic [31:0] color, col;
    box_t        cl, q;
    action_t     act;
    logic        ovf;
    clip_cmd_t   res;
    fn       = func_t'(user[1:0]);
    has_rect = user[2];
    rx       = $signed(data[15:0]);
    ry       = $signed(data[31:16]);
    rw       = data[46:32];
    rh       = data[61:47];
    sx       = $signed(data[77:62]);
    sy       = $signed(data[93:78]);
    iw       = data[108:94];
    ih       = data[123:109];
    unwind   = data[131:124];
    color    = data[163:132];
    t        = top_idx % STACK_DEPTH;
    cl       = clip_tbl[t];
    ox       = org_x[t];
    oy       = org_y[t];
    act      = ACT_NONE;
    ovf      = 1'b0;
    dx = 0; dy = 0; psx = 0; psy = 0; w = 0; h = 0;
    col      = '0;
    case (fn)
      FUNC_PUSH: begin
        if (t + 1 >= STACK_DEPTH) begin
          ovf = 1'b1;
        end else begin
          n = t + 1;
          if (!has_rect) begin
            org_x[n]    = ox;
            org_y[n]    = oy;
            clip_tbl[n] = cl;
          end else begin
            org_x[n]    = wrap_coord(ox + rx);
            org_y[n]    = wrap_coord(oy + ry);
            q.x         = org_x[n];
            q.y         = org_y[n];
            q.w         = rw;
            q.h         = rh;
            clip_tbl[n] = overlap(q, cl);
          end
          top_idx = n;
        end
      end
      FUNC_POP: begin
        n       = (unwind < t) ? unwind : t;
        top_idx = t - n;
      end
      FUNC_BLIT: begin
        dx  = ox + rx;
        dy  = oy + ry;
        psx = sx;
        psy = sy;
        w   = has_rect ? rw : iw;
        h   = has_rect ? rh : ih;
        // x axis: source left edge, clip left, image right, clip right
        if (psx < 0) begin
          w = floor0(w + psx); dx -= psx; psx = 0;
        end
        if (dx < cl.x) begin
          d = cl.x - dx; w = floor0(w - d); psx += d; dx = cl.x;
        end
        if (psx + w > iw) begin
          d = psx + w - iw; w = floor0(w - d);
        end
        if (dx + w > cl.x + cl.w) begin
          d = dx + w - (cl.x + cl.w); w = floor0(w - d);
        end
        // y axis in the same order
        if (psy < 0) begin
          h = floor0(h + psy); dy -= psy; psy = 0;
        end
        if (dy < cl.y) begin
          d = cl.y - dy; h = floor0(h - d); psy += d; dy = cl.y;
        end
        if (psy + h > ih) begin
          d = psy + h - ih; h = floor0(h - d);
        end
        if (dy + h > cl.y + cl.h) begin
          d = dy + h - (cl.y + cl.h); h = floor0(h - d);
        end
        if (w != 0 && h != 0) act = ACT_BLIT;
      end
      default: begin
        q = cl;
        if (has_rect) begin
          q.x = ox + rx;
          q.y = oy + ry;
          q.w = rw;
          q.h = rh;
          q   = overlap(q, cl);
        end
        dx = q.x;
        dy = q.y;
        w  = q.w;
        h  = q.h;
        if (w != 0 && h != 0) begin
          act = ACT_FILL;
          col = color;
        end
      end
    endcase
    // clear the fields that do not apply to this command
    if (act == ACT_NONE) begin
      dx = 0; dy = 0; psx = 0; psy = 0; w = 0; h = 0;
    end else if (act == ACT_FILL) begin
      psx = 0; psy = 0;
    end
    res.action = act;
    res.dst_x  = dx[POS_W-1:0];
    res.dst_y  = dy[POS_W-1:0];
    res.src_x  = psx[POS_W-1:0];
    res.src_y  = psy[POS_W-1:0];
    res.w      = w[SIZE_W-1:0];
    res.h      = h[SIZE_W-1:0];
    res.color  = col;
    res.level  = LEVEL_W'(top_idx + 1);
    res.ovf    = ovf;
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    $display("[%0t] vsbc mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    clip_cmd_t   want;
    logic [31:0] reg_val;
    if (rst) begin
      canvas_w    = CANVAS_W_RESET;
      canvas_h    = CANVAS_H_RESET;
      top_idx     = 0;
      org_x[0]    = 0;
      org_y[0]    = 0;
      clip_tbl[0] = '{0, 0, CANVAS_W_RESET, CANVAS_H_RESET};
      expected_cmds.delete();
    end else begin
      // register port: writes resize the base entry at once
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_CANVAS_W) begin
            canvas_w      = pwdata[SIZE_W-1:0];
            clip_tbl[0].w = canvas_w;
          end else begin
            canvas_h      = pwdata[SIZE_W-1:0];
            clip_tbl[0].h = canvas_h;
          end
        end else begin
          reg_val = (paddr[2] == REG_CANVAS_W) ? 32'(canvas_w) : 32'(canvas_h);
          check_field("prdata", prdata, reg_val);
        end
      end
      // compare before queuing, so a same-edge request never jumps ahead
      if (m_tvalid && m_tready) begin
        if (expected_cmds.size() == 0) begin
          note_mismatch("result with no request pending");
        end else begin
          want = expected_cmds.pop_front();
          check_field("action", m_tuser, want.action);
          check_field("dst_out_x", m_tdata[15:0], want.dst_x);
          check_field("dst_out_y", m_tdata[31:16], want.dst_y);
          check_field("src_out_x", m_tdata[47:32], want.src_x);
          check_field("src_out_y", m_tdata[63:48], want.src_y);
          check_field("out_w", m_tdata[78:64], want.w);
          check_field("out_h", m_tdata[93:79], want.h);
          check_field("color_out", m_tdata[125:94], want.color);
          check_field("stack_level", m_tdata[126 +: LEVEL_W], want.level);
          check_field("overflow", m_tdata[126 + LEVEL_W], want.ovf);
        end
      end
      if (s_tvalid && s_tready) expected_cmds.push_back(clip_request(s_tuser, s_tdata));
    end
    outstanding <= expected_cmds.size();
  end

endmodule

/* verif/tb_viewport_stack_blit_clipper_top.sv */
// Testbench top for the viewport stack blit clipper: reset, register setup, request stimulus, verdict.
`timescale 1ns / 100ps

module tb_viewport_stack_blit_clipper_top;
  import vsbc_pkg::*;

  localparam int LEVEL_W  = $clog2(STACK_DEPTH + 1);
  localparam int M_DATA_W = ((127 + LEVEL_W + 7) / 8) * 8;
  localparam int PHASE_ITEMS = 125;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [CFG_W-1:0]     pwdata;
  logic [CFG_W-1:0]     prdata;
  logic                 pready;
  logic                 s_tvalid;
  logic                 s_tready;
  // rect_x, rect_y, rect_w, rect_h, src_x, src_y, img_w, img_h, unwind_count, fill_color
  logic [IN_DATA_W-1:0] s_tdata;
  // func, has_rect
  logic [2:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // dst_out_x, dst_out_y, src_out_x, src_out_y, out_w, out_h, color_out, stack_level, overflow
  logic [M_DATA_W-1:0]  m_tdata;
  // action
  logic [1:0]           m_tuser;

  int errors;
  int outstanding;

  // sender burst state
  int burst_left;
  int stall_cnt = 0;

  always #5 clk = ~clk;

  viewport_stack_blit_clipper_top u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  vsbc_clip_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Receiver stall pattern: stall_cnt[8:7] switches between always ready, coin flip,
  // ready only when stall_cnt is a multiple of five (long stalls) and mostly ready.
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case ((stall_cnt >> 7) % 4)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      2:       m_tready <= (stall_cnt % 5 == 0);
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_viewport_stack_blit_clipper_top: done, errors");
    $finish;
  end

  function automatic item_t make_item(func_t fn, logic has_rect, logic [15:0] rx,
                                      logic [15:0] ry, logic [14:0] rw, logic [14:0] rh,
                                      logic [15:0] sx, logic [15:0] sy, logic [14:0] iw,
                                      logic [14:0] ih, logic [7:0] unwind,
                                      logic [31:0] color);
    item_t it;
    it.func         = fn;
    it.has_rect     = has_rect;
    it.rect_x       = rx;
    it.rect_y       = ry;
    it.rect_w       = rw;
    it.rect_h       = rh;
    it.src_x        = sx;
    it.src_y        = sy;
    it.img_w        = iw;
    it.img_h        = ih;
    it.unwind_count = unwind;
    it.fill_color   = color;
    return it;
  endfunction

  // Positions: full range, near origin, across the default canvas, or an extreme.
  function automatic logic [15:0] pick_pos();
    int v;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        v = $urandom_range(0, 200);
        return 16'(v - 100);
      end
      2: return 16'($urandom_range(0, 1200));
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'hffff;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [14:0] pick_size();
    case ($urandom_range(0, 3))
      0: return 15'($urandom);
      1: return 15'($urandom_range(0, 64));
      2: return 15'($urandom_range(0, 1200));
      default: begin
        case ($urandom_range(0, 2))
          0:       return 15'd0;
          1:       return 15'd1;
          default: return 15'h7fff;
        endcase
      end
    endcase
  endfunction

  function automatic item_t rand_any();
    return make_item(func_t'($urandom_range(0, 3)), $urandom_range(0, 1), pick_pos(),
                     pick_pos(), pick_size(), pick_size(), pick_pos(), pick_pos(),
                     pick_size(), pick_size(), 8'($urandom), $urandom);
  endfunction

  function automatic item_t rand_push();
    item_t it;
    it          = rand_any();
    it.func     = FUNC_PUSH;
    it.has_rect = ($urandom_range(0, 6) != 0);
    return it;
  endfunction

  function automatic item_t rand_draw();
    item_t it;
    it      = rand_any();
    it.func = $urandom_range(0, 1) ? FUNC_BLIT : FUNC_FILL;
    return it;
  endfunction

  function automatic item_t pop_item(logic [7:0] unwind);
    item_t it;
    it              = rand_any();
    it.func         = FUNC_POP;
    it.unwind_count = unwind;
    return it;
  endfunction

  // Hand one request to the block; hold it until taken, then maybe open a gap.
  task automatic issue_request(item_t it);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it.fill_color, it.unwind_count, it.img_h, it.img_w, it.src_y,
                 it.src_x, it.rect_h, it.rect_w, it.rect_y, it.rect_x};
    s_tuser  <= {it.has_rect, it.func};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      // a quarter of the bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    // junk in the upper bits must be ignored
    pwdata  <= ($urandom & 32'hffff8000) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The checker compares prdata on the access edge.
  task automatic reg_read(logic [PADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the request line, wait for every result to drain, then let the block settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_canvas(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    drain_results();
    reg_write({REG_CANVAS_W, 2'b00}, w);
    reg_write({REG_CANVAS_H, 2'b00}, h);
    reg_read({REG_CANVAS_W, 2'b00});
    reg_read({REG_CANVAS_H, 2'b00});
  endtask

  // Mostly well-formed nesting: push a few viewports, draw in them, unwind.
  // Some runs go deep enough to overflow, some requests are plain noise.
  task automatic run_random(int count);
    int sent_here;
    int kind;
    int pushes;
    int draws;
    sent_here = 0;
    while (sent_here < count) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        pushes = $urandom_range(1, 4);
        draws  = $urandom_range(2, 6);
        repeat (pushes) issue_request(rand_push());
        repeat (draws) issue_request(rand_draw());
        issue_request(pop_item(($urandom_range(0, 4) == 0) ?
                               8'($urandom_range(0, 6)) : 8'(pushes)));
        sent_here += pushes + draws + 1;
      end else if (kind < 17) begin
        pushes = $urandom_range(15, 18);
        repeat (pushes) issue_request(rand_push());
        issue_request(rand_draw());
        issue_request(pop_item($urandom_range(0, 1) ? 8'hff : 8'($urandom_range(16, 255))));
        sent_here += pushes + 2;
      end else begin
        issue_request(rand_any());
        sent_here++;
      end
    end
  endtask

  initial begin
    int i;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    burst_left = $urandom_range(1, 16);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values read back before anything is written
    reg_read({REG_CANVAS_W, 2'b00});
    reg_read({REG_CANVAS_H, 2'b00});

    // Directed part on the reset canvas (1024x768).
    // fill without a rectangle covers the whole clip
    issue_request(make_item(FUNC_FILL, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff));
    // fill far off the left/top: intersection saturates to empty
    issue_request(make_item(FUNC_FILL, 1'b1, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff,
                            0, 0, 0, 0, 0, 32'h12345678));
    issue_request(make_item(FUNC_FILL, 1'b1, 100, 50, 200, 100, 0, 0, 0, 0, 0, 32'h0));
    // blit without size takes the image size
    issue_request(make_item(FUNC_BLIT, 1'b0, 10, 10, 0, 0, 0, 0, 64, 64, 0, 32'hdeadbeef));
    // negative source and destination both trim the leading edge
    issue_request(make_item(FUNC_BLIT, 1'b1, 16'hfffb, 16'hfffb, 50, 50, 16'hfff6, 16'hffec,
                            40, 40, 0, 0));
    // destination runs off the right and bottom of the clip
    issue_request(make_item(FUNC_BLIT, 1'b1, 1000, 700, 100, 100, 0, 0, 100, 100, 0, 0));
    // zero-size blit is empty
    issue_request(make_item(FUNC_BLIT, 1'b1, 5, 5, 0, 10, 0, 0, 100, 100, 0, 0));
    // source at the far end of a maximal image
    issue_request(make_item(FUNC_BLIT, 1'b0, 16'h7fff, 16'h8000, 0, 0, 16'h7fff, 16'h7fff,
                            15'h7fff, 15'h7fff, 0, 0));
    // nested viewport, then one whose origin wraps the coordinate width
    issue_request(make_item(FUNC_PUSH, 1'b1, 100, 100, 300, 200, 0, 0, 0, 0, 0, 0));
    issue_request(make_item(FUNC_FILL, 1'b1, 16'hfff0, 16'hfff0, 50, 50, 0, 0, 0, 0, 0,
                            32'ha5a5a5a5));
    issue_request(make_item(FUNC_BLIT, 1'b1, 250, 150, 100, 100, 0, 0, 200, 200, 0, 0));
    issue_request(make_item(FUNC_PUSH, 1'b1, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff,
                            0, 0, 0, 0, 0, 0));
    issue_request(make_item(FUNC_FILL, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h1));
    // fill the stack and push once more to hit overflow
    for (i = 0; i < 14; i++) begin
      issue_request(make_item(FUNC_PUSH, i[0], 16'(i), 16'(i), 15'h7fff, 15'h7fff,
                              0, 0, 0, 0, 0, 0));
    end
    // pop of zero stays put, pop past the base stops at the base
    issue_request(make_item(FUNC_POP, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0, 0));
    issue_request(make_item(FUNC_POP, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd1, 0));
    issue_request(make_item(FUNC_POP, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff, 0));

    run_random(PHASE_ITEMS);

    // Canvas sweep: empty, maximal, single pixel, arbitrary, common, lopsided.
    set_canvas(15'd0, 15'd0);
    run_random(PHASE_ITEMS);
    set_canvas(15'h7fff, 15'h7fff);
    run_random(PHASE_ITEMS);
    set_canvas(15'd1, 15'd1);
    run_random(PHASE_ITEMS);
    set_canvas(15'($urandom), 15'($urandom));
    run_random(PHASE_ITEMS);
    set_canvas(15'd640, 15'd480);
    run_random(PHASE_ITEMS);
    set_canvas(15'h7fff, 15'd1);
    run_random(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    drain_results();
    if (errors == 0 && outstanding == 0) begin
      $display("tb_viewport_stack_blit_clipper_top: done, clean");
    end else begin
      $display("tb_viewport_stack_blit_clipper_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/vsbc_pkg.sv
src/vsbc_regs.sv
src/vsbc_ctrl.sv
src/vsbc_dp.sv
src/viewport_stack_blit_clipper_top.sv
verif/vsbc_clip_checker.sv
verif/tb_viewport_stack_blit_clipper_top.sv
